// ----- src/igniter_channel_arm_fire_controller_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef IGNITER_CHANNEL_ARM_FIRE_CONTROLLER_CORE_MACROS_SVH
`define IGNITER_CHANNEL_ARM_FIRE_CONTROLLER_CORE_MACROS_SVH

// Clocked assertion, masked while reset is applied.
`define ICAFC_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is checked during reset too.
`define ICAFC_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/icafc_pkg.sv -----
package icafc_pkg;

	// Channel state codes
	localparam logic [2:0] ST_DISARMED  = 3'd0;
	localparam logic [2:0] ST_NOT_READY = 3'd1;
	localparam logic [2:0] ST_ARMED     = 3'd2;
	localparam logic [2:0] ST_FIRING    = 3'd3;
	localparam logic [2:0] ST_ERROR     = 3'd4;
	localparam logic [2:0] ST_SUCCESS   = 3'd5;

	// Configuration register indexes
	localparam logic [7:0] REG_FIRE_TICKS    = 8'd0;
	localparam logic [7:0] REG_OUTPUT_ENABLE = 8'd1;

	localparam int unsigned CHANNELS_DEF = 4;
	localparam int unsigned VIS_CH       = 4;
	localparam int unsigned ST_W         = 3;
	localparam int unsigned TICK_W       = 16;
	localparam int unsigned CFG_IDX_W    = 8;
	localparam int unsigned IN_W         = 16;
	localparam int unsigned OUT_W        = 24;

	localparam logic [TICK_W-1:0] FIRE_TICKS_RST = 16'd1000;

	// Per-lane result handed to the merge stage
	typedef struct packed {
		logic [ST_W-1:0] state;
		logic            consumed;
		logic            changed;
	} lane_res_t;

endpackage

// ----- src/icafc_lane.sv -----
module icafc_lane
	import icafc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              arm,
	input  logic              rdy,
	input  logic              cmd,
	input  logic              launch,
	input  logic              poll,
	input  logic [TICK_W-1:0] fire_ticks,
	output lane_res_t         res
);

	logic [ST_W-1:0]   state_q, rep_q;
	logic [TICK_W-1:0] timer_q;
	logic [ST_W-1:0]   st_svc, st_nxt;
	logic [TICK_W-1:0] tmr_svc, tmr_nxt;
	logic              cons;

	// Service step on poll ticks, then pulse countdown on every tick
	always_comb begin
		st_svc  = state_q;
		tmr_svc = timer_q;
		cons    = 1'b0;
		if (poll) begin
			if (!arm) begin
				st_svc  = ST_DISARMED;
				tmr_svc = '0;
			end else begin
				unique case (state_q)
					ST_DISARMED: begin
						st_svc = rdy ? ST_ARMED : ST_NOT_READY;
					end
					ST_ARMED: begin
						if (launch && cmd) begin
							if (rdy) begin
								st_svc  = ST_FIRING;
								tmr_svc = fire_ticks;
								cons    = 1'b1;
							end else begin
								st_svc = ST_ERROR;
							end
						end else if (!rdy) begin
							st_svc = ST_NOT_READY;
						end
					end
					default: begin
					end
				endcase
			end
		end

		st_nxt  = st_svc;
		tmr_nxt = tmr_svc;
		if (state_q == ST_FIRING && st_svc == ST_FIRING) begin
			if (tmr_svc <= TICK_W'(1)) begin
				tmr_nxt = '0;
				st_nxt  = rdy ? ST_ERROR : ST_SUCCESS;
			end else begin
				tmr_nxt = tmr_svc - TICK_W'(1);
			end
		end
	end

	// Advance channel state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NOT_READY;
			timer_q <= '0;
			rep_q   <= ST_DISARMED;
		end else if (advance) begin
			state_q <= st_nxt;
			timer_q <= tmr_nxt;
			rep_q   <= st_nxt;
		end
	end

	assign res.state    = st_nxt;
	assign res.consumed = cons;
	assign res.changed  = (st_nxt != rep_q);

endmodule

// ----- src/icafc_merge.sv -----
module icafc_merge
	import icafc_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  lane_res_t        res [CHANNELS],
	input  logic             output_enable,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [OUT_W-1:0] m_tdata
);

	logic [VIS_CH*ST_W-1:0] states;
	logic [VIS_CH-1:0]      fire, consumed;
	logic                   changed;
	logic                   valid_q;
	logic [OUT_W-1:0]       data_q;

	// Gather visible channels, zero where no lane exists
	for (genvar c = 0; c < VIS_CH; c++) begin : g_vis
		if (c < CHANNELS) begin : g_on
			assign states[c*ST_W +: ST_W] = res[c].state;
			assign fire[c]     = output_enable && (res[c].state == ST_FIRING);
			assign consumed[c] = res[c].consumed;
		end else begin : g_off
			assign states[c*ST_W +: ST_W] = ST_DISARMED;
			assign fire[c]     = 1'b0;
			assign consumed[c] = 1'b0;
		end
	end

	// Any lane whose state moved flags the tick
	always_comb begin
		changed = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			changed = changed | res[c].changed;
		end
	end

	// Output register: load on input transfer, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {3'b000, changed, consumed, fire, states};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

// ----- src/igniter_channel_arm_fire_controller_core.sv -----
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------
// s_       | s_tvalid/s_tready  | s_tdata: arm, ready, command masks, flags
// m_       | m_tvalid/m_tready  | m_tdata: channel states, fire, consumed, chg
// cfg_     | cfg_valid/cfg_ready| cfg_index, cfg_data; always ready
//
// One tick per clock cycle unless m_tready stalls; at the input transfer the
// result loads the merge stage output register and shows the cycle after.
// Input is taken whenever the output register is empty or being drained, so
// a stall on m_tready holds the input side only while a result waits.
// arst_n clears channel states to not ready, timers to zero, registers to
// their defaults (fire_ticks 1000, output_enable 1).
module igniter_channel_arm_fire_controller_core
	import icafc_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [3:0] arm_mask, [7:4] ready_mask, [11:8] command_mask,
	// [12] launch_active, [13] poll, [15:14] zero
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [2:0] state_ch0, [5:3] state_ch1, [8:6] state_ch2, [11:9] state_ch3,
	// [15:12] fire_mask, [19:16] command_consumed, [20] status_changed,
	// [23:21] zero
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	logic [TICK_W-1:0] fire_ticks_q;
	logic              oe_q;
	logic              s_xfer;
	logic [VIS_CH-1:0] arm_m, rdy_m, cmd_m;
	lane_res_t         res [CHANNELS];

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid || m_tready;
	assign s_xfer    = s_tvalid && s_tready;

	assign arm_m = s_tdata[3:0];
	assign rdy_m = s_tdata[7:4];
	assign cmd_m = s_tdata[11:8];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_ticks_q <= FIRE_TICKS_RST;
			oe_q         <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIRE_TICKS:    fire_ticks_q <= cfg_data;
				REG_OUTPUT_ENABLE: oe_q         <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// One lane per channel; channels past the input masks see no bits
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		logic arm_b, rdy_b, cmd_b;
		if (c < VIS_CH) begin : g_in
			assign arm_b = arm_m[c];
			assign rdy_b = rdy_m[c];
			assign cmd_b = cmd_m[c];
		end else begin : g_none
			assign arm_b = 1'b0;
			assign rdy_b = 1'b0;
			assign cmd_b = 1'b0;
		end

		icafc_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (s_xfer),
			.arm        (arm_b),
			.rdy        (rdy_b),
			.cmd        (cmd_b),
			.launch     (s_tdata[12]),
			.poll       (s_tdata[13]),
			.fire_ticks (fire_ticks_q),
			.res        (res[c])
		);
	end

	icafc_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (s_xfer),
		.res           (res),
		.output_enable (oe_q),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.m_tdata       (m_tdata)
	);

endmodule

// ----- src/icafc_checker.sv -----
`include "igniter_channel_arm_fire_controller_core_macros.svh"

module icafc_checker
	import icafc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// A stalled result holds
	`ICAFC_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Every input transfer yields a result on the next cycle
	`ICAFC_ASSERT(a_result, clk, arst_n, s_tvalid && s_tready |=> m_tvalid, "input transfer gave no result")

	// Channel 0 fire drive only while it is firing
	`ICAFC_ASSERT(a_fire0, clk, arst_n, m_tvalid && m_tdata[12] |-> m_tdata[2:0] == ST_FIRING, "fire without firing state")

	// A consumed command on channel 0 means its pulse just started
	`ICAFC_ASSERT(a_cons0, clk, arst_n, m_tvalid && m_tdata[16] |-> m_tdata[2:0] == ST_FIRING, "command consumed without firing")

endmodule

bind igniter_channel_arm_fire_controller_core icafc_checker u_icafc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import icafc_pkg::*;

	localparam int CLK_HALF   = 4;
	localparam int RST_CYCLES = 11;
	localparam int HOLD_LEN   = 200;
	localparam int STALL_MAX  = 3000;
	localparam int RES_W      = 21;

	// One tick as it travels on s_tdata, lowest field last
	typedef struct packed {
		logic [1:0] pad;
		logic       poll;
		logic       launch;
		logic [3:0] cmd;
		logic [3:0] rdy;
		logic [3:0] arm;
	} tick_in_t;

	// One tick result as it travels on m_tdata[20:0]
	typedef struct packed {
		logic            changed;
		logic [3:0]      consumed;
		logic [3:0]      fire;
		logic [3:0][2:0] state;
	} tick_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_data  = '0;

	// Channel model state and register copies
	logic [2:0]        ch_state [4];
	logic [TICK_W-1:0] ch_timer [4];
	logic [2:0]        shown_state [4];
	logic [TICK_W-1:0] pulse_len    = FIRE_TICKS_RST;
	logic              drive_enable = 1'b1;

	tick_in_t     tick_queue[$];
	tick_result_t expected_ticks[$];

	int  mismatches    = 0;
	int  result_count  = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  stall_cycles  = 0;
	int  hold_cnt      = 0;
	bit  hold_req      = 1'b0;
	bit  hold_started  = 1'b0;
	bit  in_taken      = 1'b0;

	igniter_channel_arm_fire_controller_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Advance the channel state machines by one tick and return what it shows
	function automatic tick_result_t advance_tick(tick_in_t t);
		tick_result_t r;
		bit           was_firing [4];
		r = '0;
		for (int c = 0; c < 4; c++)
			was_firing[c] = (ch_state[c] == ST_FIRING);
		// service on poll ticks
		if (t.poll) begin
			for (int c = 0; c < 4; c++) begin
				if (!t.arm[c]) begin
					ch_state[c] = ST_DISARMED;
					ch_timer[c] = '0;
				end else if (ch_state[c] == ST_DISARMED) begin
					ch_state[c] = t.rdy[c] ? ST_ARMED : ST_NOT_READY;
				end else if (ch_state[c] == ST_ARMED) begin
					if (t.launch && t.cmd[c]) begin
						if (t.rdy[c]) begin
							ch_state[c] = ST_FIRING;
							ch_timer[c] = pulse_len;
							r.consumed[c] = 1'b1;
						end else begin
							ch_state[c] = ST_ERROR;
						end
					end else if (!t.rdy[c]) begin
						ch_state[c] = ST_NOT_READY;
					end
				end
			end
		end
		// run pulses already under way; a zero length ends like one tick
		for (int c = 0; c < 4; c++) begin
			if (was_firing[c] && ch_state[c] == ST_FIRING) begin
				if (ch_timer[c] <= 1) begin
					ch_timer[c] = '0;
					ch_state[c] = t.rdy[c] ? ST_ERROR : ST_SUCCESS;
				end else begin
					ch_timer[c] = ch_timer[c] - 1'b1;
				end
			end
		end
		// report changes against the last shown states
		for (int c = 0; c < 4; c++) begin
			if (shown_state[c] != ch_state[c]) begin
				shown_state[c] = ch_state[c];
				r.changed = 1'b1;
			end
			r.state[c] = ch_state[c];
			r.fire[c]  = (ch_state[c] == ST_FIRING) && drive_enable;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("result %0d: %s is %0d, expected %0d", result_count, field, got, want);
		mismatches++;
	endtask

	task automatic push_tick(logic [3:0] arm, logic [3:0] rdy, logic [3:0] cmd,
			logic launch, logic poll);
		tick_in_t t;
		t = '{pad: 2'b00, poll: poll, launch: launch, cmd: cmd, rdy: rdy, arm: arm};
		tick_queue.push_back(t);
	endtask

	// Mostly plausible switch traffic, with some fully random noise
	task automatic push_random_ticks(int count);
		tick_in_t t;
		for (int i = 0; i < count; i++) begin
			t = '0;
			if ($urandom_range(0, 99) < 10) begin
				t = tick_in_t'(16'($urandom));
				t.pad = 2'b00;
			end else begin
				for (int c = 0; c < 4; c++) begin
					t.arm[c] = ($urandom_range(0, 99) < 85);
					t.rdy[c] = ($urandom_range(0, 99) < 75);
					t.cmd[c] = ($urandom_range(0, 99) < 50);
				end
				t.launch = ($urandom_range(0, 99) < 80);
				t.poll   = ($urandom_range(0, 99) < 85);
			end
			tick_queue.push_back(t);
		end
	endtask

	// Wait until every tick is sent and every result is back
	task automatic wait_drained();
		while (tick_queue.size() != 0 || s_tvalid || expected_ticks.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FIRE_TICKS)
			pulse_len = val;
		else if (idx == REG_OUTPUT_ENABLE)
			drive_enable = val[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender: present the next pending tick, or idle
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tdata  <= tick_queue.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && !hold_started) begin
			hold_started = 1'b1;
			hold_cnt     = HOLD_LEN;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Check each result transfer, then predict from each input transfer
	always @(posedge clk) begin
		tick_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (expected_ticks.size() == 0) begin
				report_mismatch("unexpected result", int'(m_tdata), 0);
			end else begin
				want = expected_ticks.pop_front();
				got  = tick_result_t'(m_tdata[RES_W-1:0]);
				for (int c = 0; c < 4; c++)
					if (got.state[c] !== want.state[c])
						report_mismatch($sformatf("state_ch%0d", c), int'(got.state[c]),
							int'(want.state[c]));
				if (got.fire !== want.fire)
					report_mismatch("fire_mask", int'(got.fire), int'(want.fire));
				if (got.consumed !== want.consumed)
					report_mismatch("command_consumed", int'(got.consumed),
						int'(want.consumed));
				if (got.changed !== want.changed)
					report_mismatch("status_changed", int'(got.changed), int'(want.changed));
				if (m_tdata[OUT_W-1:RES_W] !== '0)
					report_mismatch("padding", int'(m_tdata[OUT_W-1:RES_W]), 0);
			end
		end
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken)
			expected_ticks.push_back(advance_tick(tick_in_t'(s_tdata)));
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_MAX) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < 4; c++) begin
			ch_state[c]    = ST_NOT_READY;
			ch_timer[c]    = '0;
			shown_state[c] = ST_DISARMED;
		end
		repeat (RST_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset settings, first tick flags a change
		push_tick(4'h0, 4'h0, 4'h0, 1'b0, 1'b0);
		push_tick(4'hF, 4'hF, 4'hF, 1'b1, 1'b1);
		push_tick(4'h0, 4'h0, 4'h0, 1'b0, 1'b1);
		push_tick(4'hF, 4'hA, 4'h0, 1'b0, 1'b1);
		push_tick(4'hF, 4'hF, 4'hF, 1'b0, 1'b1);
		push_tick(4'hF, 4'h2, 4'hA, 1'b1, 1'b1);
		push_tick(4'h0, 4'h2, 4'hF, 1'b1, 1'b0);
		push_tick(4'hD, 4'hF, 4'h0, 1'b0, 1'b1);
		wait_drained();

		// directed: short pulses ending in error and success
		write_register(REG_FIRE_TICKS, 16'd2);
		write_register(REG_OUTPUT_ENABLE, 16'd1);
		push_tick(4'h0, 4'hF, 4'h0, 1'b0, 1'b1);
		push_tick(4'hF, 4'hF, 4'h0, 1'b0, 1'b1);
		push_tick(4'hF, 4'h7, 4'h0, 1'b1, 1'b1);
		push_tick(4'hF, 4'hF, 4'h3, 1'b1, 1'b1);
		push_tick(4'hF, 4'h1, 4'h0, 1'b0, 1'b0);
		push_tick(4'hF, 4'h1, 4'hF, 1'b1, 1'b1);
		push_tick(4'hF, 4'hF, 4'hF, 1'b1, 1'b1);
		push_tick(4'h0, 4'hF, 4'hF, 1'b1, 1'b1);
		wait_drained();

		// random, no idling
		write_register(REG_FIRE_TICKS, 16'd3);
		push_random_ticks(90);
		wait_drained();

		// zero pulse length, outputs held low, sender idles
		write_register(REG_FIRE_TICKS, 16'd0);
		write_register(REG_OUTPUT_ENABLE, 16'd0);
		send_idle_pct = 75;
		push_random_ticks(80);
		wait_drained();

		// longest pulse, receiver stalls
		write_register(REG_FIRE_TICKS, 16'hFFFF);
		write_register(REG_OUTPUT_ENABLE, 16'd1);
		send_idle_pct  = 0;
		recv_stall_pct = 75;
		push_random_ticks(70);
		wait_drained();

		// one-tick pulses, both sides idle a little
		write_register(REG_FIRE_TICKS, 16'd1);
		send_idle_pct  = 13;
		recv_stall_pct = 13;
		push_random_ticks(90);
		wait_drained();

		// unknown index is dropped; long receiver hold-off backs up the input
		write_register(8'd2, 16'hFFFF);
		write_register(REG_FIRE_TICKS, 16'd6);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		push_random_ticks(70);
		wait_drained();

		repeat (5) @(negedge clk);
		if (expected_ticks.size() != 0)
			report_mismatch("missing results", 0, expected_ticks.size());
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
